// ----- rtl/mmrc_pkg.sv -----
// Shared types, constants and the descriptor classifier for the memory map
// region coalescer. No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps

package mmrc_pkg;

  localparam int MAX_REGIONS_DEF = 256;
  localparam int PAGE_SHIFT      = 12;
  localparam int QDEPTH          = 4;
  localparam int QA_W            = $clog2(QDEPTH);

  // UEFI memory type codes
  localparam logic [3:0] T_RESERVED  = 4'd0;
  localparam logic [3:0] T_LDR_CODE  = 4'd1;
  localparam logic [3:0] T_LDR_DATA  = 4'd2;
  localparam logic [3:0] T_BS_CODE   = 4'd3;
  localparam logic [3:0] T_BS_DATA   = 4'd4;
  localparam logic [3:0] T_CONV      = 4'd7;
  localparam logic [3:0] T_UNUSABLE  = 4'd8;
  localparam logic [3:0] T_ACPI_RECL = 4'd9;
  localparam logic [3:0] T_ACPI_NVS  = 4'd10;

  // Internal region classes; unusable is reported as class 7 plus a flag
  localparam logic [3:0] C_RAM       = 4'd0;
  localparam logic [3:0] C_RESERVED  = 4'd1;
  localparam logic [3:0] C_ACPI      = 4'd2;
  localparam logic [3:0] C_NVS       = 4'd3;
  localparam logic [3:0] C_LDR_CODE  = 4'd4;
  localparam logic [3:0] C_LDR_DATA  = 4'd5;
  localparam logic [3:0] C_BS_CODE   = 4'd6;
  localparam logic [3:0] C_BS_DATA   = 4'd7;
  localparam logic [3:0] C_UNUSABLE  = 4'd8;

  typedef struct packed {
    logic       keep;
    logic [3:0] cls;
  } cls_res_t;

  // A finished region as handed from the front to the back. The end is
  // 65 bits so that an address end beyond 2^64 keeps its carry.
  typedef struct packed {
    logic [63:0] start;
    logic [64:0] end_a;
    logic [3:0]  cls;
    logic [3:0]  src;
    logic        fin;
    logic        ovf;
  } rec_t;

  typedef struct packed {
    logic room2;
    logic nonempty;
  } q_stat_t;

  function automatic cls_res_t classify(input logic [3:0] t, input logic wb,
                                        input logic ebs);
    cls_res_t r;
    r.keep = 1'b1;
    r.cls  = C_RESERVED;
    case (t)
      T_RESERVED:  r.cls = C_RESERVED;
      T_LDR_CODE:  r.cls = C_LDR_CODE;
      T_LDR_DATA:  r.cls = C_LDR_DATA;
      T_BS_CODE:   r.cls = !ebs ? C_BS_CODE : (wb ? C_RAM : C_RESERVED);
      T_BS_DATA:   r.cls = !ebs ? C_BS_DATA : (wb ? C_RAM : C_RESERVED);
      T_CONV:      r.cls = wb ? C_RAM : C_RESERVED;
      T_UNUSABLE:  r.cls = C_UNUSABLE;
      T_ACPI_RECL: r.cls = C_ACPI;
      T_ACPI_NVS:  r.cls = C_NVS;
      default:     r.keep = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mmrc_front.sv -----
// Front end: registers each descriptor, classifies it, holds the pending
// region and merges RAM into it. Finished regions go out as rec_t records.
// Depends on mmrc_pkg.
`timescale 1ns / 1ps

module mmrc_front #(
  parameter int MAX_REGIONS = mmrc_pkg::MAX_REGIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ebs,
  input  logic                  push,
  output logic                  full,
  input  logic [3:0]            in_mem_type,
  input  logic [63:0]           in_phys_start,
  input  logic [51:0]           in_page_count,
  input  logic                  in_write_back,
  input  logic                  in_last_descriptor,
  input  mmrc_pkg::q_stat_t     q_stat,
  output logic [1:0]            wr_cnt,
  output mmrc_pkg::rec_t        rec0,
  output mmrc_pkg::rec_t        rec1
);
  import mmrc_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // input stage
  logic        s0_v_r;
  logic [3:0]  s0_type_r;
  logic [63:0] s0_start_r;
  logic [64:0] s0_end_r;
  logic [3:0]  s0_cls_r;
  logic        s0_keep_r;
  logic        s0_last_r;

  // pending region and per-map state
  logic             pv_r, pv_nxt;
  logic [63:0]      ps_r, ps_nxt;
  logic [64:0]      pe_r, pe_nxt;
  logic [3:0]       pc_r, pc_nxt;
  logic [3:0]       psrc_r, psrc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  cls_res_t    cr;
  logic [63:0] size_in;
  logic        accept, go;
  logic        merge, open, ovf_set;
  logic [64:0] merged_end;
  rec_t        rec_a, rec_b;

  assign full   = s0_v_r && !q_stat.room2;
  assign accept = push && !full;
  assign go     = s0_v_r && q_stat.room2;

  assign cr      = classify(in_mem_type, in_write_back, ebs);
  assign size_in = {in_page_count, PAGE_SHIFT'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (accept) begin
      s0_v_r <= 1'b1;
    end else if (go) begin
      s0_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_type_r  <= in_mem_type;
      s0_start_r <= in_phys_start;
      s0_end_r   <= {1'b0, in_phys_start} + {1'b0, size_in};
      s0_cls_r   <= cr.cls;
      s0_keep_r  <= cr.keep && (in_page_count != '0);
      s0_last_r  <= in_last_descriptor;
    end
  end

  // A RAM descriptor joins the held RAM region when the held end reaches its
  // start and no overflow is flagged; the new end is the larger 65-bit end.
  always_comb begin
    merge = s0_keep_r && (s0_cls_r == C_RAM) && pv_r && (pc_r == C_RAM) && !ovf_r &&
            (pe_r >= {1'b0, s0_start_r});
    merged_end = (pe_r > s0_end_r) ? pe_r : s0_end_r;
    open    = s0_keep_r && !merge && (cnt_r < CNT_W'(MAX_REGIONS));
    ovf_set = s0_keep_r && !merge && !(cnt_r < CNT_W'(MAX_REGIONS));

    pv_nxt   = pv_r;
    ps_nxt   = ps_r;
    pe_nxt   = pe_r;
    pc_nxt   = pc_r;
    psrc_nxt = psrc_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r || ovf_set;
    if (open) begin
      pv_nxt   = 1'b1;
      ps_nxt   = s0_start_r;
      pe_nxt   = s0_end_r;
      pc_nxt   = s0_cls_r;
      psrc_nxt = s0_type_r;
      cnt_nxt  = cnt_r + CNT_W'(1);
    end else if (merge) begin
      pe_nxt = merged_end;
    end

    rec_a.start = ps_r;
    rec_a.end_a = pe_r;
    rec_a.cls   = pc_r;
    rec_a.src   = psrc_r;
    rec_a.fin   = 1'b0;
    rec_a.ovf   = ovf_r;

    rec_b.start = ps_nxt;
    rec_b.end_a = pe_nxt;
    rec_b.cls   = pc_nxt;
    rec_b.src   = psrc_nxt;
    rec_b.fin   = 1'b1;
    rec_b.ovf   = ovf_nxt;

    wr_cnt = 2'd0;
    rec0   = rec_a;
    rec1   = rec_b;
    if (go) begin
      if (open && pv_r) begin
        wr_cnt = (s0_last_r && pv_nxt) ? 2'd2 : 2'd1;
      end else if (s0_last_r && pv_nxt) begin
        wr_cnt = 2'd1;
        rec0   = rec_b;
      end
    end

    // The last descriptor of a map returns all map state to reset.
    if (s0_last_r) begin
      pv_nxt  = 1'b0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (go) begin
      pv_r  <= pv_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ps_r   <= ps_nxt;
      pe_r   <= pe_nxt;
      pc_r   <= pc_nxt;
      psrc_r <= psrc_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (go && s0_last_r) |=> (!pv_r && cnt_r == '0 && !ovf_r))
    else $error("map state not cleared after last descriptor");

  assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r == 1'b0) |-> (cnt_r == '0))
    else $error("region count without a held region");

endmodule

// ----- rtl/mmrc_queue.sv -----
// Short queue of region records between front and back: up to two writes
// and one read per cycle. Depends on mmrc_pkg.
`timescale 1ns / 1ps

module mmrc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         wr_cnt,
  input  mmrc_pkg::rec_t     wr0,
  input  mmrc_pkg::rec_t     wr1,
  input  logic               rd_en,
  output mmrc_pkg::rec_t     rd_data,
  output mmrc_pkg::q_stat_t  stat
);
  import mmrc_pkg::*;

  rec_t            mem [QDEPTH];
  logic [QA_W-1:0] head_r, tail_r;
  logic [QA_W:0]   count_r;

  assign rd_data       = mem[head_r];
  assign stat.nonempty = (count_r != '0);
  assign stat.room2    = (count_r <= (QA_W+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[tail_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[tail_r + QA_W'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + QA_W'(wr_cnt);
      head_r  <= head_r + QA_W'(rd_en);
      count_r <= count_r + (QA_W+1)'(wr_cnt) - (QA_W+1)'(rd_en);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QA_W+1)'(QDEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> stat.nonempty)
    else $error("read from empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_cnt != 2'd0) |-> stat.room2)
    else $error("write into queue without room");

endmodule

// ----- rtl/mmrc_back.sv -----
// Back end: takes region records from the queue, computes the saturated
// size, keeps the running RAM totals and holds the result item for the
// output side. Depends on mmrc_pkg.
`timescale 1ns / 1ps

module mmrc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mmrc_pkg::q_stat_t  q_stat,
  input  mmrc_pkg::rec_t     q_data,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        out_region_start,
  output logic [63:0]        out_region_size,
  output logic [2:0]         out_region_class,
  output logic               out_region_unusable,
  output logic [3:0]         out_source_type,
  output logic               out_final_region,
  output logic [63:0]        out_total_ram_bytes,
  output logic [63:0]        out_largest_ram_bytes,
  output logic               out_table_overflow
);
  import mmrc_pkg::*;

  logic        s1_v_r;
  logic [63:0] s1_start_r, s1_size_r;
  logic [3:0]  s1_cls_r, s1_src_r;
  logic        s1_fin_r, s1_ovf_r;

  logic        ov_r;
  logic [63:0] tot_r, tot_nxt, lg_r, lg_nxt;
  logic [63:0] tot_sum, lg_new;

  logic        adv_out, s1_move;
  logic [64:0] diff, sum;

  assign adv_out = !ov_r || pop;
  assign s1_move = s1_v_r && adv_out;
  assign q_rd    = q_stat.nonempty && (!s1_v_r || adv_out);
  assign empty   = !ov_r;

  // An end at least 2^64 past the start saturates the size.
  assign diff = q_data.end_a - {1'b0, q_data.start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (q_rd) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_start_r <= q_data.start;
      s1_size_r  <= diff[64] ? '1 : diff[63:0];
      s1_cls_r   <= q_data.cls;
      s1_src_r   <= q_data.src;
      s1_fin_r   <= q_data.fin;
      s1_ovf_r   <= q_data.ovf;
    end
  end

  always_comb begin
    sum    = {1'b0, tot_r} + {1'b0, s1_size_r};
    tot_sum = tot_r;
    lg_new  = lg_r;
    if (s1_cls_r == C_RAM) begin
      tot_sum = sum[64] ? '1 : sum[63:0];
      lg_new  = (s1_size_r > lg_r) ? s1_size_r : lg_r;
    end
    tot_nxt = s1_fin_r ? '0 : tot_sum;
    lg_nxt  = s1_fin_r ? '0 : lg_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      tot_r <= '0;
      lg_r  <= '0;
    end else begin
      if (s1_move) begin
        ov_r  <= 1'b1;
        tot_r <= tot_nxt;
        lg_r  <= lg_nxt;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_region_start      <= s1_start_r;
      out_region_size       <= s1_size_r;
      out_region_class      <= (s1_cls_r >= C_UNUSABLE) ? 3'(C_BS_DATA) : s1_cls_r[2:0];
      out_region_unusable   <= (s1_cls_r == C_UNUSABLE);
      out_source_type       <= s1_src_r;
      out_final_region      <= s1_fin_r;
      out_total_ram_bytes   <= tot_sum;
      out_largest_ram_bytes <= lg_new;
      out_table_overflow    <= s1_ovf_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_fin_r) |=> (tot_r == '0 && lg_r == '0))
    else $error("RAM totals not cleared after final region");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> (out_total_ram_bytes >= out_largest_ram_bytes))
    else $error("largest RAM region exceeds RAM total");

endmodule

// ----- rtl/memory_map_region_coalescer.sv -----
// Memory map region coalescer, top level: configuration register, front end,
// record queue and back end. Depends on mmrc_pkg, mmrc_front, mmrc_queue
// and mmrc_back.
//
// Usage: descriptors enter on the in_ ports with push; an item is taken at
// a clock edge with push high and full low. Result items leave on the out_
// ports; the oldest is shown while empty is low and is taken with pop.
// cfg_wr_en writes cfg_wr_data into the boot-exit register; write it only
// while the block is idle.
// A descriptor that releases a region shows it on the out_ ports once it has
// passed the input register, the record queue, the size stage and the output
// register, when nothing is stalled.
// Throughput: one descriptor per cycle while full is low. A descriptor can
// release two regions; the back end delivers at most one result item per
// cycle, so a run of them fills the four-entry queue and full rises.
// Reset (rst_n low at a clock edge) empties all stages and the queue, drops
// any held region and clears the boot-exit register. When pop stays low, the
// result is held, the back end and then the queue fill, and full rises; no
// item is lost.
`timescale 1ns / 1ps

module memory_map_region_coalescer #(
  parameter int MAX_REGIONS = mmrc_pkg::MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  in_mem_type,
  input  logic [63:0] in_phys_start,
  input  logic [51:0] in_page_count,
  input  logic        in_write_back,
  input  logic        in_last_descriptor,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_region_start,
  output logic [63:0] out_region_size,
  output logic [2:0]  out_region_class,
  output logic        out_region_unusable,
  output logic [3:0]  out_source_type,
  output logic        out_final_region,
  output logic [63:0] out_total_ram_bytes,
  output logic [63:0] out_largest_ram_bytes,
  output logic        out_table_overflow
);
  import mmrc_pkg::*;

  logic      ebs_r;
  q_stat_t   q_stat;
  logic [1:0] wr_cnt;
  rec_t      rec0, rec1, q_data;
  logic      q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebs_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ebs_r <= cfg_wr_data;
    end
  end

  mmrc_front #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .ebs               (ebs_r),
    .push              (push),
    .full              (full),
    .in_mem_type       (in_mem_type),
    .in_phys_start     (in_phys_start),
    .in_page_count     (in_page_count),
    .in_write_back     (in_write_back),
    .in_last_descriptor(in_last_descriptor),
    .q_stat            (q_stat),
    .wr_cnt            (wr_cnt),
    .rec0              (rec0),
    .rec1              (rec1)
  );

  mmrc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cnt (wr_cnt),
    .wr0    (rec0),
    .wr1    (rec1),
    .rd_en  (q_rd),
    .rd_data(q_data),
    .stat   (q_stat)
  );

  mmrc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_data               (q_data),
    .q_rd                 (q_rd),
    .empty                (empty),
    .pop                  (pop),
    .out_region_start     (out_region_start),
    .out_region_size      (out_region_size),
    .out_region_class     (out_region_class),
    .out_region_unusable  (out_region_unusable),
    .out_source_type      (out_source_type),
    .out_final_region     (out_final_region),
    .out_total_ram_bytes  (out_total_ram_bytes),
    .out_largest_ram_bytes(out_largest_ram_bytes),
    .out_table_overflow   (out_table_overflow)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for memory_map_region_coalescer: sends descriptor maps,
// predicts every emitted region in a scoreboard class and compares each result item.
// Depends on rtl/mmrc_pkg.sv and rtl/memory_map_region_coalescer.sv.
`timescale 1ns / 1ps

module testbench;
  import mmrc_pkg::*;

  localparam int ITEM_TARGET  = 1950;
  localparam int QUIET_TAIL   = 300;
  localparam int PHASE_ITEMS  = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [51:0] PAGES_MAX = '1;
  localparam logic [3:0] T_UNLISTED_LO  = 4'd5;
  localparam logic [3:0] T_UNLISTED_MID = 4'd6;
  localparam logic [3:0] T_UNLISTED_HI  = 4'd15;
  localparam logic [3:0] KEPT_TYPES [0:8] = '{T_RESERVED, T_LDR_CODE, T_LDR_DATA,
                                              T_BS_CODE, T_BS_DATA, T_CONV,
                                              T_UNUSABLE, T_ACPI_RECL, T_ACPI_NVS};

  typedef struct packed {
    logic [3:0]  mem_type;
    logic [63:0] start;
    logic [51:0] pages;
    logic        wb;
    logic        last;
  } descriptor_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
    logic [2:0]  cls;
    logic        unusable;
    logic [3:0]  src;
    logic        fin;
    logic [63:0] ram_total;
    logic [63:0] ram_largest;
    logic        overflow;
  } region_t;

  class region_scoreboard;
    logic        boot_exit;
    logic        holding;
    logic [63:0] held_start;
    logic [63:0] held_size;
    logic [3:0]  held_class;
    logic [3:0]  held_source;
    int unsigned regions_opened;
    logic [63:0] ram_sum;
    logic [63:0] ram_peak;
    logic        table_full;
    region_t     expected_regions[$];
    int unsigned mismatches;

    function new();
      boot_exit = 1'b0;
      mismatches = 0;
      clear_map();
    endfunction

    function void clear_map();
      holding = 1'b0;
      held_start = '0;
      held_size = '0;
      held_class = C_RAM;
      held_source = '0;
      regions_opened = 0;
      ram_sum = '0;
      ram_peak = '0;
      table_full = 1'b0;
    endfunction

    function void write_cfg(logic v);
      boot_exit = v;
    endfunction

    function int outstanding();
      return expected_regions.size();
    endfunction

    // Upper bit says whether the descriptor is kept, the rest is its class.
    function logic [4:0] decode_type(logic [3:0] t, logic wb);
      logic [3:0] ram_or_rsvd;
      ram_or_rsvd = wb ? C_RAM : C_RESERVED;
      case (t)
        T_RESERVED:  return {1'b1, C_RESERVED};
        T_LDR_CODE:  return {1'b1, C_LDR_CODE};
        T_LDR_DATA:  return {1'b1, C_LDR_DATA};
        T_BS_CODE:   return {1'b1, (boot_exit ? ram_or_rsvd : C_BS_CODE)};
        T_BS_DATA:   return {1'b1, (boot_exit ? ram_or_rsvd : C_BS_DATA)};
        T_CONV:      return {1'b1, ram_or_rsvd};
        T_UNUSABLE:  return {1'b1, C_UNUSABLE};
        T_ACPI_RECL: return {1'b1, C_ACPI};
        T_ACPI_NVS:  return {1'b1, C_NVS};
        default:     return '0;
      endcase
    endfunction

    function void release_held(logic fin);
      region_t r;
      logic [64:0] sum;
      if (held_class == C_RAM) begin
        sum = {1'b0, ram_sum} + {1'b0, held_size};
        ram_sum = sum[64] ? '1 : sum[63:0];
        if (held_size > ram_peak) ram_peak = held_size;
      end
      r.start = held_start;
      r.size = held_size;
      r.cls = (held_class >= C_UNUSABLE) ? C_BS_DATA[2:0] : held_class[2:0];
      r.unusable = (held_class == C_UNUSABLE);
      r.src = held_source;
      r.fin = fin;
      r.ram_total = ram_sum;
      r.ram_largest = ram_peak;
      r.overflow = table_full;
      expected_regions.push_back(r);
    endfunction

    function void note_descriptor(descriptor_t d);
      logic [4:0]  decoded;
      logic [63:0] bytes;
      logic [64:0] held_end;
      logic [64:0] new_end;
      logic [64:0] span;
      logic        merged;
      if (d.pages != '0) begin
        bytes = {d.pages, 12'h000};
        decoded = decode_type(d.mem_type, d.wb);
        if (decoded[4]) begin
          merged = 1'b0;
          // Ends are kept at 65 bits so that an end past 2^64 reaches any start.
          if (decoded[3:0] == C_RAM && holding && held_class == C_RAM && !table_full) begin
            held_end = {1'b0, held_start} + {1'b0, held_size};
            new_end = {1'b0, d.start} + {1'b0, bytes};
            if (held_end >= {1'b0, d.start}) begin
              span = ((held_end > new_end) ? held_end : new_end) - {1'b0, held_start};
              held_size = span[64] ? '1 : span[63:0];
              merged = 1'b1;
            end
          end
          if (!merged) begin
            if (regions_opened < MAX_REGIONS_DEF) begin
              if (holding) release_held(1'b0);
              holding = 1'b1;
              held_start = d.start;
              held_size = bytes;
              held_class = decoded[3:0];
              held_source = d.mem_type;
              regions_opened++;
            end else begin
              table_full = 1'b1;
            end
          end
        end
      end
      if (d.last) begin
        if (holding) release_held(1'b1);
        clear_map();
      end
    endfunction

    function void flag(string what, region_t want, region_t got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
        $display("region mismatch:%s", what);
        $display("  expected start=%h size=%h class=%0d unusable=%0b source=%0d final=%0b",
                 want.start, want.size, want.cls, want.unusable, want.src, want.fin);
        $display("           total=%h largest=%h overflow=%0b",
                 want.ram_total, want.ram_largest, want.overflow);
        $display("  actual   start=%h size=%h class=%0d unusable=%0b source=%0d final=%0b",
                 got.start, got.size, got.cls, got.unusable, got.src, got.fin);
        $display("           total=%h largest=%h overflow=%0b",
                 got.ram_total, got.ram_largest, got.overflow);
      end
    endfunction

    function void check_region(region_t got);
      region_t want;
      string diff;
      if (expected_regions.size() == 0) begin
        flag(" no region was expected", '0, got);
        return;
      end
      want = expected_regions.pop_front();
      diff = "";
      if (got.start !== want.start) diff = {diff, " start"};
      if (got.size !== want.size) diff = {diff, " size"};
      if (got.cls !== want.cls) diff = {diff, " class"};
      if (got.unusable !== want.unusable) diff = {diff, " unusable"};
      if (got.src !== want.src) diff = {diff, " source"};
      if (got.fin !== want.fin) diff = {diff, " final"};
      if (got.ram_total !== want.ram_total) diff = {diff, " total"};
      if (got.ram_largest !== want.ram_largest) diff = {diff, " largest"};
      if (got.overflow !== want.overflow) diff = {diff, " overflow"};
      if (diff != "") flag(diff, want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        push;
  logic        full;
  logic [3:0]  in_mem_type;
  logic [63:0] in_phys_start;
  logic [51:0] in_page_count;
  logic        in_write_back;
  logic        in_last_descriptor;
  logic        empty;
  logic        pop;
  logic [63:0] out_region_start;
  logic [63:0] out_region_size;
  logic [2:0]  out_region_class;
  logic        out_region_unusable;
  logic [3:0]  out_source_type;
  logic        out_final_region;
  logic [63:0] out_total_ram_bytes;
  logic [63:0] out_largest_ram_bytes;
  logic        out_table_overflow;

  region_scoreboard tracker;
  int unsigned      cycles;
  int               sent;
  bit               slack_on;
  bit               hold_long;
  bit               hold_served;

  memory_map_region_coalescer uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .push                  (push),
    .full                  (full),
    .in_mem_type           (in_mem_type),
    .in_phys_start         (in_phys_start),
    .in_page_count         (in_page_count),
    .in_write_back         (in_write_back),
    .in_last_descriptor    (in_last_descriptor),
    .empty                 (empty),
    .pop                   (pop),
    .out_region_start      (out_region_start),
    .out_region_size       (out_region_size),
    .out_region_class      (out_region_class),
    .out_region_unusable   (out_region_unusable),
    .out_source_type       (out_source_type),
    .out_final_region      (out_final_region),
    .out_total_ram_bytes   (out_total_ram_bytes),
    .out_largest_ram_bytes (out_largest_ram_bytes),
    .out_table_overflow    (out_table_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Everything is sampled at the edge, before any register of this step updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.write_cfg(cfg_wr_data);
      if (push && !full) begin
        tracker.note_descriptor('{in_mem_type, in_phys_start, in_page_count,
                                  in_write_back, in_last_descriptor});
      end
      if (pop && !empty) begin
        tracker.check_region('{out_region_start, out_region_size, out_region_class,
                               out_region_unusable, out_source_type, out_final_region,
                               out_total_ram_bytes, out_largest_ram_bytes,
                               out_table_overflow});
      end
    end
  end

  initial begin
    pop <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long && !hold_served) begin
        // Long hold so that the queue fills and the input side stalls.
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else if (slack_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic descriptor_t make_desc(logic [3:0] t, logic [63:0] start,
                                            logic [51:0] pages, logic wb, logic last);
    descriptor_t d;
    d.mem_type = t;
    d.start = start;
    d.pages = pages;
    d.wb = wb;
    d.last = last;
    return d;
  endfunction

  function automatic logic [3:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return T_CONV;
      5:             return T_BS_CODE;
      6:             return T_BS_DATA;
      7, 8:          return KEPT_TYPES[$urandom_range(0, 8)];
      default:       return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [51:0] pick_pages();
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2:       return r[51:0];
      3:       return PAGES_MAX - 52'($urandom_range(0, 3));
      4:       return 52'(r[15:0]);
      default: return 52'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_descriptor(input descriptor_t d);
    if (slack_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    in_mem_type <= d.mem_type;
    in_phys_start <= d.start;
    in_page_count <= d.pages;
    in_write_back <= d.wb;
    in_last_descriptor <= d.last;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Waits until every expected region has come out, then lets the pipeline drain.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_boot_exit(input logic v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_directed();
    descriptor_t plan[$];
    // Merging, classes and dropped codes with boot services still running.
    plan.push_back(make_desc(T_CONV, 64'h1000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h2000, 52'd2, 1'b1, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h2000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h4000, 52'd1, 1'b0, 1'b0));
    plan.push_back(make_desc(T_BS_CODE, 64'h5000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_BS_DATA, 64'h6000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_RESERVED, 64'h7000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_LDR_CODE, 64'h8000, 52'd1, 1'b0, 1'b0));
    plan.push_back(make_desc(T_LDR_DATA, 64'h9000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_UNUSABLE, 64'hA000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_ACPI_RECL, 64'hB000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_ACPI_NVS, 64'hC000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_UNLISTED_LO, 64'h0, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h20000, 52'd0, 1'b1, 1'b0));
    // A RAM region ending exactly at 2^64, then a merge that also wraps.
    plan.push_back(make_desc(T_CONV, 64'hFFFF_FFFF_FFFF_F000, 52'd1, 1'b1, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h2000, PAGES_MAX, 1'b1, 1'b0));
    plan.push_back(make_desc(T_UNLISTED_MID, 64'h0, 52'd0, 1'b0, 1'b1));
    plan.push_back(make_desc(T_UNLISTED_HI, 64'h0, 52'd5, 1'b1, 1'b1));
    // Size saturation on merge, then total saturation on the next RAM region.
    plan.push_back(make_desc(T_CONV, '1, PAGES_MAX, 1'b1, 1'b0));
    plan[$].start = 64'h0;
    plan.push_back(make_desc(T_CONV, 64'h1000, PAGES_MAX, 1'b1, 1'b0));
    plan.push_back(make_desc(T_ACPI_RECL, 64'h0, 52'd1, 1'b0, 1'b0));
    plan.push_back(make_desc(T_CONV, 64'h0, 52'd1, 1'b1, 1'b1));
    foreach (plan[i]) send_descriptor(plan[i]);
    set_boot_exit(1'b1);
    send_descriptor(make_desc(T_BS_CODE, 64'h1000, 52'd1, 1'b1, 1'b0));
    send_descriptor(make_desc(T_BS_DATA, 64'h2000, 52'd1, 1'b1, 1'b0));
    send_descriptor(make_desc(T_BS_DATA, 64'h3000, 52'd1, 1'b0, 1'b1));
  endtask

  task automatic send_wellformed_map();
    int          n;
    logic [63:0] cursor;
    descriptor_t d;
    n = $urandom_range(1, 14);
    cursor = rand64() & ~64'hFFF;
    if ($urandom_range(0, 9) == 0) cursor = 64'd0 - (64'($urandom_range(1, 64)) << 12);
    for (int i = 0; i < n; i++) begin
      d.mem_type = pick_type();
      d.wb = ($urandom_range(0, 7) != 0);
      d.pages = pick_pages();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: d.start = cursor;
        6:                d.start = cursor - (64'($urandom_range(1, 4)) << 12);
        7, 8:             d.start = cursor + (64'($urandom_range(1, 16)) << 12);
        default:          d.start = rand64();
      endcase
      d.last = (i == n - 1);
      cursor = d.start + {d.pages, 12'h000};
      send_descriptor(d);
    end
  endtask

  task automatic send_noise_map();
    int          n;
    logic [63:0] r;
    descriptor_t d;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      r = rand64();
      d.mem_type = 4'($urandom_range(0, 15));
      d.start = rand64();
      d.pages = $urandom_range(0, 1) ? r[51:0] : 52'(r[3:0]);
      d.wb = 1'($urandom_range(0, 1));
      d.last = (i == n - 1) || ($urandom_range(0, 9) == 0);
      send_descriptor(d);
    end
  endtask

  // Fills the region table, ends on a RAM region, then offers one region too many
  // followed by RAM that would grow the held region if the table were not full.
  task automatic send_full_table_map();
    descriptor_t d;
    for (int i = 0; i < MAX_REGIONS_DEF + 12; i++) begin
      if (i < MAX_REGIONS_DEF - 1) begin
        d = make_desc(KEPT_TYPES[$urandom_range(0, 8)], 64'(i) << 20,
                      52'($urandom_range(1, 8)), 1'($urandom_range(0, 1)), 1'b0);
      end else if (i == MAX_REGIONS_DEF - 1) begin
        d = make_desc(T_CONV, 64'(i) << 20, 52'd1, 1'b1, 1'b0);
      end else if (i == MAX_REGIONS_DEF) begin
        d = make_desc(T_ACPI_NVS, 64'h4000_0000, 52'd2, 1'b0, 1'b0);
      end else begin
        d = make_desc(T_CONV, (64'(MAX_REGIONS_DEF - 1) << 20) + (64'(i - MAX_REGIONS_DEF) << 12),
                      52'd1, 1'b1, (i == MAX_REGIONS_DEF + 11));
      end
      send_descriptor(d);
    end
  endtask

  initial begin
    int phase_end;
    tracker = new();
    rst_n <= 1'b0;
    push <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_mem_type <= '0;
    in_phys_start <= '0;
    in_page_count <= '0;
    in_write_back <= 1'b0;
    in_last_descriptor <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_boot_exit(1'b0);
    slack_on = 1'b1;
    send_directed();
    for (int p = 0; sent < ITEM_TARGET; p++) begin
      set_boot_exit(1'(p % 2));
      if (p == 1) hold_long = 1'b1;
      if (p == 2) send_full_table_map();
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < ITEM_TARGET) begin
        slack_on = (sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 5) == 0) begin
          send_noise_map();
        end else begin
          send_wellformed_map();
        end
      end
    end
    settle();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mmrc_pkg.sv
rtl/mmrc_front.sv
rtl/mmrc_queue.sv
rtl/mmrc_back.sv
rtl/memory_map_region_coalescer.sv
tb/sv/testbench.sv
